@@ hdl/ptw_pkg.sv @@
// Package for the four-level page table walker: field widths, level codes,
// request codes and page table entry bit positions. No dependencies.
`default_nettype none

package ptw_pkg;

    localparam int PA_W          = 52;
    localparam int VA_W          = 48;
    localparam int DATA_W        = 64;
    localparam int WADDR_W       = 12;
    localparam int LVL_W         = 2;
    localparam int PAGE_BITS     = 12;
    localparam int IDX_W         = 9;
    localparam int MEM_WORDS_DEF = 4096;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_WALK  = 1'b1;

    // Table levels, top first.
    localparam logic [LVL_W-1:0] LVL_PML4 = 2'd0;
    localparam logic [LVL_W-1:0] LVL_PDPT = 2'd1;
    localparam logic [LVL_W-1:0] LVL_PD   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_PT   = 2'd3;

    // Entry bits.
    localparam int PTE_PRESENT_BIT = 0;
    localparam int PTE_LARGE_BIT   = 7;

endpackage

`default_nettype wire

@@ hdl/ptw_if.sv @@
// Valid/ready channel interfaces of the page table walker: the request
// channel and the result channel. Depends on ptw_pkg.
`default_nettype none

interface ptw_req_if
    import ptw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [WADDR_W-1:0] mem_word_addr;
    logic [DATA_W-1:0]  mem_data;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    root_pa;

    modport source (
        output valid, req_type, mem_word_addr, mem_data, virt_addr, root_pa,
        input  ready
    );
    modport sink (
        input  valid, req_type, mem_word_addr, mem_data, virt_addr, root_pa,
        output ready
    );
endinterface

interface ptw_rsp_if
    import ptw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LVL_W-1:0]  final_level;
    logic [PA_W-1:0]   entry_pa;
    logic [DATA_W-1:0] entry_value;
    logic [PA_W-1:0]   pdpte_pa;
    logic              pdpte_reached;
    logic [PA_W-1:0]   pde_pa;
    logic              pde_reached;
    logic              range_error;

    modport source (
        output valid, final_level, entry_pa, entry_value, pdpte_pa, pdpte_reached,
               pde_pa, pde_reached, range_error,
        input  ready
    );
    modport sink (
        input  valid, final_level, entry_pa, entry_value, pdpte_pa, pdpte_reached,
               pde_pa, pde_reached, range_error,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/four_level_page_table_walker.sv @@
// Top level of the four-level page table walker: table memory, walk
// sequencer and result register. Depends on ptw_pkg and ptw_if.
`default_nettype none

// Usage
// The req channel carries one beat per item. A write beat (req_type 0)
// stores mem_data at word mem_word_addr of the internal table memory; its
// result beat has every field zero. A walk beat (req_type 1) translates
// virt_addr starting from the table at root_pa and returns one rsp beat
// with the final entry, its address and level, the PDPT and PD entry
// addresses and the range flag.
// Timing
// Each walk level reads one entry from the single-port table memory,
// whose read data are registered. While a walk is in progress the
// sequencer holds req not ready, so the next walk or write waits for it;
// writes can be accepted every cycle while rsp is not stalled. The
// result beat appears in the cycle after the sequencer finishes.
// Stalls and reset
// Results go through an output register, so the sequencer takes a new
// request while a finished result is still waiting on rsp. If rsp stays
// stalled and the next item is finished too, that item is held and req
// drops ready until the output register frees up. Reset clears the
// sequencer and the output valid; the table memory is not cleared and
// must be written before it is walked.

module four_level_page_table_walker
    import ptw_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    ptw_req_if.sink     req,
    ptw_rsp_if.source   rsp
);

    localparam int WA = $clog2(MEM_WORDS);
    localparam int WORD_W = PA_W - 3;
    localparam logic [WORD_W-1:0] MEM_LIMIT = WORD_W'(MEM_WORDS);
    localparam int FRAME_W = PA_W - PAGE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Table memory, one 64-bit word per entry.
    logic [DATA_W-1:0] table_mem [MEM_WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    logic              mem_we;
    logic [WA-1:0]     mem_widx;
    logic              mem_re;
    logic [WA-1:0]     mem_ridx;

    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [PA_W-1:0]   pa_reg, pa_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [VA_W-PAGE_BITS-1:0] va_reg, va_next;
    logic [PA_W-1:0]   pdpte_pa_reg, pdpte_pa_next;
    logic              pdpte_r_reg, pdpte_r_next;
    logic [PA_W-1:0]   pde_pa_reg, pde_pa_next;
    logic              pde_r_reg, pde_r_next;
    logic              rerr_reg, rerr_next;

    logic              out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]  out_level_reg, out_level_next;
    logic [PA_W-1:0]   out_pa_reg, out_pa_next;
    logic [DATA_W-1:0] out_val_reg, out_val_next;
    logic [PA_W-1:0]   out_pdpte_pa_reg, out_pdpte_pa_next;
    logic              out_pdpte_r_reg, out_pdpte_r_next;
    logic [PA_W-1:0]   out_pde_pa_reg, out_pde_pa_next;
    logic              out_pde_r_reg, out_pde_r_next;
    logic              out_rerr_reg, out_rerr_next;

    logic              out_free;
    logic              req_ready;
    logic              accept;
    logic [WORD_W-1:0] waddr_ext;
    logic [PA_W-1:0]   root_entry_pa;
    logic [PA_W-1:0]   next_entry_pa;
    logic [IDX_W-1:0]  next_idx;
    logic              stop;

    // The output register can take a result when empty or being drained.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_ready = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign accept    = req.valid && req_ready;
    assign req.ready = req_ready;

    assign waddr_ext = WORD_W'(req.mem_word_addr);

    // Table bases are page aligned, so an entry address is the frame with
    // the 9-bit index and a zero byte offset appended: no adder is needed.
    assign root_entry_pa = {req.root_pa[PA_W-1:PAGE_BITS],
                            req.virt_addr[VA_W-1:VA_W-IDX_W], 3'b000};

    always_comb
    begin
        case (level_reg)
            LVL_PML4: next_idx = va_reg[3*IDX_W-1:2*IDX_W];
            LVL_PDPT: next_idx = va_reg[2*IDX_W-1:IDX_W];
            LVL_PD:   next_idx = va_reg[IDX_W-1:0];
            default:  next_idx = '0;
        endcase
    end

    assign next_entry_pa = {rd_data_reg[PA_W-1:PAGE_BITS], next_idx, 3'b000};

    assign stop = !rd_data_reg[PTE_PRESENT_BIT]
               || (((level_reg == LVL_PDPT) || (level_reg == LVL_PD))
                   && rd_data_reg[PTE_LARGE_BIT])
               || (level_reg == LVL_PT);

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        pa_next        = pa_reg;
        val_next       = val_reg;
        va_next        = va_reg;
        pdpte_pa_next  = pdpte_pa_reg;
        pdpte_r_next   = pdpte_r_reg;
        pde_pa_next    = pde_pa_reg;
        pde_r_next     = pde_r_reg;
        rerr_next      = rerr_reg;

        out_valid_next    = out_valid_reg && !rsp.ready;
        out_level_next    = out_level_reg;
        out_pa_next       = out_pa_reg;
        out_val_next      = out_val_reg;
        out_pdpte_pa_next = out_pdpte_pa_reg;
        out_pdpte_r_next  = out_pdpte_r_reg;
        out_pde_pa_next   = out_pde_pa_reg;
        out_pde_r_next    = out_pde_r_reg;
        out_rerr_next     = out_rerr_reg;

        mem_we   = 1'b0;
        mem_widx = waddr_ext[WA-1:0];
        mem_re   = 1'b0;
        mem_ridx = '0;

        case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                // The entry at pa_reg has been read and is in rd_data_reg.
                if (level_reg == LVL_PDPT)
                begin
                    pdpte_pa_next = pa_reg;
                    pdpte_r_next  = 1'b1;
                end
                else if (level_reg == LVL_PD)
                begin
                    pde_pa_next = pa_reg;
                    pde_r_next  = 1'b1;
                end
                if (stop)
                begin
                    val_next   = rd_data_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    level_next = level_reg + LVL_W'(1);
                    pa_next    = next_entry_pa;
                    if (next_entry_pa[PA_W-1:3] < MEM_LIMIT)
                    begin
                        mem_re   = 1'b1;
                        mem_ridx = next_entry_pa[WA+2:3];
                    end
                    else
                    begin
                        rerr_next  = 1'b1;
                        val_next   = '0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_level_next    = level_reg;
                    out_pa_next       = pa_reg;
                    out_val_next      = val_reg;
                    out_pdpte_pa_next = pdpte_pa_reg;
                    out_pdpte_r_next  = pdpte_r_reg;
                    out_pde_pa_next   = pde_pa_reg;
                    out_pde_r_next    = pde_r_reg;
                    out_rerr_next     = rerr_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new request starts from a clean result.
        if (accept)
        begin
            level_next    = LVL_PML4;
            val_next      = '0;
            pdpte_pa_next = '0;
            pdpte_r_next  = 1'b0;
            pde_pa_next   = '0;
            pde_r_next    = 1'b0;
            rerr_next     = 1'b0;
            if (req.req_type == REQ_WRITE)
            begin
                pa_next    = '0;
                mem_we     = (waddr_ext < MEM_LIMIT);
                state_next = ST_FINISH;
            end
            else
            begin
                va_next = req.virt_addr[VA_W-1:PAGE_BITS];
                pa_next = root_entry_pa;
                if (root_entry_pa[PA_W-1:3] < MEM_LIMIT)
                begin
                    mem_re     = 1'b1;
                    mem_ridx   = root_entry_pa[WA+2:3];
                    state_next = ST_CHECK;
                end
                else
                begin
                    rerr_next  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
        end
    end

    // Single-port table memory; a write and a read never share a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_widx] <= req.mem_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_ridx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg        <= level_next;
        pa_reg           <= pa_next;
        val_reg          <= val_next;
        va_reg           <= va_next;
        pdpte_pa_reg     <= pdpte_pa_next;
        pdpte_r_reg      <= pdpte_r_next;
        pde_pa_reg       <= pde_pa_next;
        pde_r_reg        <= pde_r_next;
        rerr_reg         <= rerr_next;
        out_level_reg    <= out_level_next;
        out_pa_reg       <= out_pa_next;
        out_val_reg      <= out_val_next;
        out_pdpte_pa_reg <= out_pdpte_pa_next;
        out_pdpte_r_reg  <= out_pdpte_r_next;
        out_pde_pa_reg   <= out_pde_pa_next;
        out_pde_r_reg    <= out_pde_r_next;
        out_rerr_reg     <= out_rerr_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.final_level   = out_level_reg;
    assign rsp.entry_pa      = out_pa_reg;
    assign rsp.entry_value   = out_val_reg;
    assign rsp.pdpte_pa      = out_pdpte_pa_reg;
    assign rsp.pdpte_reached = out_pdpte_r_reg;
    assign rsp.pde_pa        = out_pde_pa_reg;
    assign rsp.pde_reached   = out_pde_r_reg;
    assign rsp.range_error   = out_rerr_reg;

    // Keep the frame width tied to the page size.
    localparam int FRAME_CHECK = FRAME_W;
    if (FRAME_CHECK != PA_W - PAGE_BITS)
    begin : g_bad_frame
        $error("frame width mismatch");
    end

endmodule

`default_nettype wire

@@ hdl/ptw_checker.sv @@
// Port-level checks on the result channel of the page table walker, bound
// to the top level. Depends on ptw_pkg and four_level_page_table_walker.
`default_nettype none

module ptw_checker
    import ptw_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [LVL_W-1:0]  final_level,
    input wire logic [PA_W-1:0]   entry_pa,
    input wire logic [DATA_W-1:0] entry_value,
    input wire logic              pdpte_reached,
    input wire logic              pde_reached,
    input wire logic              range_error
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its entry address, entry value and level.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(entry_pa) && $stable(entry_value)
                                    && $stable(final_level))
        else $error("result payload changed while stalled");

    // An entry outside the memory is never read, so its value is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && range_error |-> entry_value == '0)
        else $error("out-of-range entry carries a value");

    // Reaching a PD entry means the PDPT entry was read first.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && pde_reached |-> pdpte_reached
                                     && (final_level == LVL_PD || final_level == LVL_PT))
        else $error("PD entry reached without the PDPT level");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .final_level   (rsp.final_level),
    .entry_pa      (rsp.entry_pa),
    .entry_value   (rsp.entry_value),
    .pdpte_reached (rsp.pdpte_reached),
    .pde_reached   (rsp.pde_reached),
    .range_error   (rsp.range_error)
);

`default_nettype wire
